// ----- hdl/acd_pkg.sv -----
// Shared types and constants for the aging cache directory.
// No dependencies; imported by aging_cache_directory.
`timescale 1ns / 1ps
`default_nettype none

package acd_pkg;

  localparam int unsigned ACD_ENTRIES     = 1024;
  localparam int unsigned ACD_HANDLE_BITS = 16;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned OUT_HW   = 16;
  localparam int unsigned AGE_W    = 4;
  localparam int unsigned COUNT_W  = 11;

  localparam logic [AGE_W-1:0]   MAX_AGE_RESET = 4'd4;
  localparam logic [AGE_W-1:0]   AGE_LIMIT     = 4'd15;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT   = 11'd2047;

  typedef enum logic [FUNC_W-1:0] {
    FN_GET     = 2'd0,
    FN_ADD     = 2'd1,
    FN_TICK    = 2'd2,
    FN_DISCARD = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_SWEEP,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/aging_cache_directory.sv -----
// Aging cache directory: handle store with idle ages, one RMW memory.
// Depends on acd_pkg.
// Get and add run through a read stage and a write-back stage on one memory
// with a registered read port and write-to-read forwarding; a new get or add
// is taken every cycle while results are being taken. An age tick or a
// discard walks the whole memory one entry per cycle and returns its result
// once the walk and its last write-back are done; no item is taken meanwhile.
// After reset a clearing pass writes every entry before the first item
// is taken; max_age writes are taken at any time and the port is always ready.
`timescale 1ns / 1ps
`default_nettype none

module aging_cache_directory
  import acd_pkg::*;
#(
  parameter int unsigned ENTRIES     = ACD_ENTRIES,
  parameter int unsigned HANDLE_BITS = ACD_HANDLE_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [AGE_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [FUNC_W-1:0]  func,
  input  wire logic [INDEX_W-1:0] entry_index,
  input  wire logic [OUT_HW-1:0]  new_handle,
  input  wire logic               handle_present,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    hit,
  output logic [OUT_HW-1:0]       handle_out,
  output logic                    released,
  output logic [COUNT_W-1:0]      released_count
);

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned WORD_W = 1 + AGE_W + HANDLE_BITS;
  localparam int unsigned AGE_LO = HANDLE_BITS;
  localparam int unsigned VLD_B  = HANDLE_BITS + AGE_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  logic [WORD_W-1:0] mem [ENTRIES];
  logic [WORD_W-1:0] rd_data;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;

  state_t state, state_next;

  logic [AGE_W-1:0]   max_age;
  logic [IDX_W-1:0]   ptr;
  logic               sw_issue;
  logic               sw_wb_valid;
  logic [IDX_W-1:0]   sw_wb_addr;
  logic               sweep_discard;
  logic [COUNT_W-1:0] count;

  logic                   fwd_hit;
  logic [WORD_W-1:0]      fwd_data;

  logic                   s1_valid;
  logic                   s1_add;
  logic                   s1_in_range;
  logic [IDX_W-1:0]       s1_addr;
  logic [HANDLE_BITS-1:0] s1_nh;
  logic                   s1_present;

  logic                   out_free;
  logic                   adv;
  logic                   acc;
  logic                   is_access;
  logic                   load_sweep;

  logic [31:0]            idx_wide;
  logic                   in_range;
  logic [IDX_W-1:0]       in_addr;
  logic [63:0]            nh_wide;
  logic [HANDLE_BITS-1:0] in_nh;

  logic [WORD_W-1:0]      cur;
  logic                   cur_valid;
  logic [AGE_W-1:0]       cur_age;
  logic [HANDLE_BITS-1:0] cur_handle;
  logic [63:0]            cur_handle_wide;
  logic [WORD_W-1:0]      s1_wr_data;
  logic                   r_hit;
  logic                   r_rel;
  logic [OUT_HW-1:0]      r_handle;

  logic [AGE_W-1:0]       age_inc;
  logic                   sweep_drop;
  logic [WORD_W-1:0]      sweep_wr_data;

  assign cfg_ready = 1'b1;

  // input decode
  assign idx_wide  = 32'(entry_index);
  assign in_range  = idx_wide < 32'(ENTRIES);
  assign in_addr   = idx_wide[IDX_W-1:0];
  assign nh_wide   = 64'(new_handle);
  assign in_nh     = nh_wide[HANDLE_BITS-1:0];
  assign is_access = (func_t'(func) == FN_GET) || (func_t'(func) == FN_ADD);

  assign out_free = !out_valid || !out_stall;
  assign adv      = s1_valid && out_free;
  assign acc      = in_valid && !in_stall;

  // current entry with forwarding
  assign cur             = fwd_hit ? fwd_data : rd_data;
  assign cur_valid       = cur[VLD_B];
  assign cur_age         = cur[VLD_B-1:AGE_LO];
  assign cur_handle      = cur[HANDLE_BITS-1:0];
  assign cur_handle_wide = 64'(cur_handle);

  always_comb begin
    r_hit      = 1'b0;
    r_rel      = 1'b0;
    r_handle   = '0;
    s1_wr_data = {cur_valid, {AGE_W{1'b0}}, cur_handle};
    if (s1_in_range) begin
      if (s1_add) begin
        r_rel      = cur_valid && (!s1_present || (cur_handle != s1_nh));
        s1_wr_data = {s1_present, {AGE_W{1'b0}},
                      s1_present ? s1_nh : {HANDLE_BITS{1'b0}}};
      end else begin
        r_hit = cur_valid;
      end
      if (r_hit || r_rel) begin
        r_handle = cur_handle_wide[OUT_HW-1:0];
      end
    end
  end

  // sweep modify
  always_comb begin
    age_inc = (cur_age == AGE_LIMIT) ? cur_age : cur_age + AGE_W'(1);
    if (sweep_discard) begin
      sweep_drop    = cur_valid;
      sweep_wr_data = {1'b0, {AGE_W{1'b0}}, cur_handle};
    end else begin
      sweep_drop    = cur_valid && (age_inc > max_age);
      sweep_wr_data = {cur_valid && !sweep_drop, age_inc, cur_handle};
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (ptr == LAST) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (acc && !is_access) state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (!sw_issue && !sw_wb_valid) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_RUN;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall   = 1'b1;
    rd_addr    = in_addr;
    wr_en      = 1'b0;
    wr_addr    = ptr;
    wr_data    = '0;
    load_sweep = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        wr_en = 1'b1;
      end
      ST_RUN: begin
        in_stall = s1_valid && !out_free;
        rd_addr  = (s1_valid && !adv) ? s1_addr : in_addr;
        wr_en    = adv && s1_in_range;
        wr_addr  = s1_addr;
        wr_data  = s1_wr_data;
      end
      ST_SWEEP: begin
        rd_addr = ptr;
        wr_en   = sw_wb_valid;
        wr_addr = sw_wb_addr;
        wr_data = sweep_wr_data;
      end
      ST_DONE: begin
        load_sweep = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      max_age     <= MAX_AGE_RESET;
      ptr         <= '0;
      sw_issue    <= 1'b0;
      sw_wb_valid <= 1'b0;
      fwd_hit     <= 1'b0;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state   <= state_next;
      fwd_hit <= wr_en && (wr_addr == rd_addr);
      if (cfg_valid && cfg_ready) begin
        max_age <= cfg_data;
      end
      sw_wb_valid <= (state == ST_SWEEP) && sw_issue;
      if (state == ST_CLEAR) begin
        ptr <= ptr + IDX_W'(1);
      end else if (acc && !is_access) begin
        ptr      <= '0;
        sw_issue <= 1'b1;
      end else if ((state == ST_SWEEP) && sw_issue) begin
        if (ptr == LAST) begin
          sw_issue <= 1'b0;
        end else begin
          ptr <= ptr + IDX_W'(1);
        end
      end
      if (acc && is_access) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv || load_sweep) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    fwd_data   <= wr_data;
    sw_wb_addr <= ptr;
    if (acc && is_access) begin
      s1_add      <= (func_t'(func) == FN_ADD);
      s1_in_range <= in_range;
      s1_addr     <= in_addr;
      s1_nh       <= in_nh;
      s1_present  <= handle_present;
    end
    if (acc && !is_access) begin
      sweep_discard <= (func_t'(func) == FN_DISCARD);
      count         <= '0;
    end else if (sw_wb_valid && sweep_drop && (count != COUNT_LIMIT)) begin
      count <= count + COUNT_W'(1);
    end
    if (adv) begin
      hit            <= r_hit;
      handle_out     <= r_handle;
      released       <= r_rel;
      released_count <= '0;
    end else if (load_sweep) begin
      hit            <= 1'b0;
      handle_out     <= '0;
      released       <= 1'b0;
      released_count <= count;
    end
  end

  a_sweep_alone: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> !s1_valid)
    else $error("access stage busy during sweep");

  a_run_write_src: assert property (@(posedge clk) disable iff (rst)
    (wr_en && (state == ST_RUN)) |-> (s1_valid && s1_in_range))
    else $error("write in run state without access stage");

  a_done_return: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DONE) && out_free) |=> (state == ST_RUN) && out_valid)
    else $error("sweep result not loaded");

  a_count_only_sweep: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (hit || released)) |-> (released_count == '0))
    else $error("count reported with access result");

endmodule

`default_nettype wire
